// ===== sv/wto_pkg.sv =====
package wto_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS    = 16;
	localparam int ADDR_BITS      = 10;
	localparam int FREQ_BITS      = 32;
	localparam int SOR_BITS       = 32;
	localparam int START_BITS     = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	// freq (Q16.16) times size_over_rate (Q0.32) is a Q16.48 entry count
	localparam int PROD_FRAC_BITS = 48;

	// output queue
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SIZE_OVER_RATE = 2'd0,
		CFG_INTERPOLATE    = 2'd1,
		CFG_START_PHASE    = 2'd2
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// decoded operation of an accepted item
	typedef struct packed {
		logic load;
		logic tick;
		logic restart;
	} op_t;

endpackage

// ===== sv/wto_if.sv =====
// input item channel
interface wto_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            kind;
	logic [wto_pkg::ADDR_BITS-1:0]         address;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] entry;
	logic signed [wto_pkg::FREQ_BITS-1:0]  freq;

	modport source (output valid, kind, address, entry, freq, input ready);
	modport sink (input valid, kind, address, entry, freq, output ready);
endinterface

// result channel
interface wto_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

// register write channel
interface wto_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wto_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [wto_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/wavetable_oscillator.sv =====
// Wavetable oscillator with optional linear interpolation between table entries.
// item channel: kind selects a table load (address, entry), a tick (freq)
// or a phase restart. Only a tick produces a transfer on the result channel,
// carrying the sample at the phase before that tick's advance.
// cfg channel: always ready; writes size_over_rate, interpolate and
// start_phase by register index. Write it only while no item is in flight.
// A tick's sample is registered in tick_s1, then push_s2, then the result
// queue. Throughput: one item per cycle while item.ready is high; the phase
// read-modify-write forwards the updated phase to the next lookup, and the
// table reads both neighbors in the same cycle through two read ports.
// A four-entry result queue decouples the sides: item.ready drops only when
// the queue plus the ticks in flight would fill it, so a stalled receiver
// stops intake after a few ticks and nothing is lost.
// Reset: phase is zero, size_over_rate zero, interpolate on, start_phase
// zero. Table contents are undefined until loaded.
module wavetable_oscillator #(
	parameter int TABLE_SIZE = 1024,
	parameter int FRAC_BITS  = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	wto_item_if.sink      item,
	wto_result_if.source  result,
	wto_cfg_if.sink       cfg
);

	localparam int IDX_BITS = $clog2(TABLE_SIZE);
	localparam int AEXT     = IDX_BITS + wto_pkg::ADDR_BITS;
	localparam int CB       = wto_pkg::OUT_CNT_BITS;

	logic [wto_pkg::SOR_BITS-1:0]   size_over_rate_q;
	logic                           interpolate_q;
	logic [wto_pkg::START_BITS-1:0] start_phase_q;

	wto_pkg::op_t         op;
	logic                 accept;
	logic [AEXT-1:0]      addr_ext;
	logic [IDX_BITS-1:0]  rd_idx;
	logic [FRAC_BITS-1:0] frac_s1;
	logic                 tick_s1;
	wto_pkg::sample_t     t0_s1;
	wto_pkg::sample_t     t1_s1;
	logic                 push_s2;
	wto_pkg::sample_t     sample_s2;
	logic [CB-1:0]        q_count;
	logic [CB:0]          occupancy;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_over_rate_q <= '0;
			interpolate_q    <= 1'b1;
			start_phase_q    <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (wto_pkg::cfg_reg_t'(cfg.index))
				wto_pkg::CFG_SIZE_OVER_RATE: size_over_rate_q <= cfg.data;
				wto_pkg::CFG_INTERPOLATE:    interpolate_q    <= cfg.data[0];
				wto_pkg::CFG_START_PHASE: begin
					start_phase_q <= cfg.data[wto_pkg::START_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	// intake held off when the result queue could not take another sample
	assign occupancy  = (CB+1)'(q_count) + (CB+1)'(tick_s1) + (CB+1)'(push_s2);
	assign item.ready = occupancy < (CB+1)'(wto_pkg::OUT_DEPTH);
	assign accept     = item.valid && item.ready;

	// decode the accepted item
	assign op.load    = accept && (item.kind == wto_pkg::KIND_LOAD);
	assign op.tick    = accept && (item.kind == wto_pkg::KIND_TICK);
	assign op.restart = accept && (item.kind == wto_pkg::KIND_RESTART);

	assign addr_ext = AEXT'(item.address);

	wto_table #(
		.IDX_BITS (IDX_BITS)
	) u_table (
		.clk     (clk),
		.wr_en   (op.load),
		.wr_addr (addr_ext[IDX_BITS-1:0]),
		.wr_data (item.entry),
		.rd_en   (op.tick),
		.rd_addr (rd_idx),
		.t0_s1   (t0_s1),
		.t1_s1   (t1_s1)
	);

	wto_phase #(
		.IDX_BITS  (IDX_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_phase (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.freq           (item.freq),
		.size_over_rate (size_over_rate_q),
		.start_phase    (start_phase_q),
		.rd_idx         (rd_idx),
		.frac_s1        (frac_s1),
		.tick_s1        (tick_s1)
	);

	wto_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_s1     (tick_s1),
		.frac_s1     (frac_s1),
		.t0_s1       (t0_s1),
		.t1_s1       (t1_s1),
		.interpolate (interpolate_q),
		.push_s2     (push_s2),
		.sample_s2   (sample_s2)
	);

	wto_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push_s2),
		.push_sample (sample_s2),
		.count       (q_count),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_tick_to_queue: assert property (@(posedge clk) disable iff (!arst_n)
		op.tick |-> ##2 push_s2)
		else $error("accepted tick did not reach the result queue");
`endif

endmodule

// ===== sv/wto_table.sv =====
module wto_table #(
	parameter int IDX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_BITS-1:0]   wr_addr,
	input  wto_pkg::sample_t      wr_data,
	input  logic                  rd_en,
	input  logic [IDX_BITS-1:0]   rd_addr,
	output wto_pkg::sample_t      t0_s1,
	output wto_pkg::sample_t      t1_s1
);

	localparam int DEPTH = 1 << IDX_BITS;

	wto_pkg::sample_t    mem [DEPTH];
	logic [IDX_BITS-1:0] rd_addr_next;

	// neighbor entry wraps to entry 0 past the end
	assign rd_addr_next = rd_addr + IDX_BITS'(1);

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			t0_s1 <= mem[rd_addr];
			t1_s1 <= mem[rd_addr_next];
		end
	end

endmodule

// ===== sv/wto_phase.sv =====
module wto_phase #(
	parameter int IDX_BITS  = 10,
	parameter int FRAC_BITS = 22
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wto_pkg::op_t                         op,
	input  logic signed [wto_pkg::FREQ_BITS-1:0] freq,
	input  logic [wto_pkg::SOR_BITS-1:0]         size_over_rate,
	input  logic [wto_pkg::START_BITS-1:0]       start_phase,
	output logic [IDX_BITS-1:0]                  rd_idx,
	output logic [FRAC_BITS-1:0]                 frac_s1,
	output logic                                 tick_s1
);

	localparam int PHASE_BITS = IDX_BITS + FRAC_BITS;
	localparam int PROD_BITS  = wto_pkg::FREQ_BITS + wto_pkg::SOR_BITS + 1;
	localparam int SHIFT      = wto_pkg::PROD_FRAC_BITS - FRAC_BITS;
	localparam int START_EXT  = PHASE_BITS + wto_pkg::START_BITS;

	logic [PHASE_BITS-1:0]       phase_q;
	logic [PHASE_BITS-1:0]       phase_d;
	logic [PHASE_BITS-1:0]       inc_s1;
	logic                        restart_s1;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] prod_shift;
	logic [START_EXT-1:0]        start_ext;
	logic [PHASE_BITS-1:0]       restart_val;

	// increment: signed freq times unsigned factor, floored to phase units
	assign prod       = $signed(freq) * $signed({1'b0, size_over_rate});
	assign prod_shift = prod >>> SHIFT;

	// restart phase: start_phase / 65536 of one full cycle
	assign start_ext   = {start_phase, PHASE_BITS'(0)};
	assign restart_val = start_ext[START_EXT-1:wto_pkg::START_BITS];

	// phase after the item in stage 1, forwarded to the lookup of the next item
	always_comb begin
		priority if (tick_s1) begin
			phase_d = phase_q + inc_s1;
		end else if (restart_s1) begin
			phase_d = restart_val;
		end else begin
			phase_d = phase_q;
		end
	end

	assign rd_idx  = phase_d[PHASE_BITS-1:FRAC_BITS];
	assign frac_s1 = phase_q[FRAC_BITS-1:0];

	// control and phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			tick_s1    <= 1'b0;
			restart_s1 <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			tick_s1    <= op.tick;
			restart_s1 <= op.restart;
		end
	end

	// registered increment
	always_ff @(posedge clk) begin
		if (op.tick) begin
			inc_s1 <= prod_shift[PHASE_BITS-1:0];
		end
	end

`ifndef SYNTHESIS
	a_one_op_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!(tick_s1 && restart_s1))
		else $error("tick and restart both in stage 1");

	a_restart_lands: assert property (@(posedge clk) disable iff (!arst_n)
		restart_s1 |=> phase_q == $past(restart_val))
		else $error("restart did not load the start phase");
`endif

endmodule

// ===== sv/wto_interp.sv =====
module wto_interp #(
	parameter int FRAC_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_s1,
	input  logic [FRAC_BITS-1:0] frac_s1,
	input  wto_pkg::sample_t     t0_s1,
	input  wto_pkg::sample_t     t1_s1,
	input  logic                 interpolate,
	output logic                 push_s2,
	output wto_pkg::sample_t     sample_s2
);

	localparam int SB        = wto_pkg::SAMPLE_BITS;
	localparam int DIFF_BITS = SB + 1;
	localparam int MUL_BITS  = FRAC_BITS + 1 + DIFF_BITS;

	logic signed [DIFF_BITS-1:0] diff;
	logic signed [MUL_BITS-1:0]  mul;
	logic signed [MUL_BITS-1:0]  mul_s2;
	logic signed [MUL_BITS-1:0]  mul_shift;
	wto_pkg::sample_t            t0_s2;

	// slope toward the next entry, zero for a truncating lookup
	assign diff = interpolate ? (DIFF_BITS'(t1_s1) - DIFF_BITS'(t0_s1)) : '0;
	assign mul  = $signed({1'b0, frac_s1}) * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s2 <= 1'b0;
		end else begin
			push_s2 <= tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= mul;
		t0_s2  <= t0_s1;
	end

	// floor of the weighted slope, always between t0 and t1
	assign mul_shift = mul_s2 >>> FRAC_BITS;
	assign sample_s2 = t0_s2 + wto_pkg::sample_t'(mul_shift[SB-1:0]);

endmodule

// ===== sv/wto_outq.sv =====
module wto_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  wto_pkg::sample_t                    push_sample,
	output logic [wto_pkg::OUT_CNT_BITS-1:0]    count,
	wto_result_if.source                        result
);

	localparam int DEPTH = wto_pkg::OUT_DEPTH;
	localparam int PB    = wto_pkg::OUT_PTR_BITS;
	localparam int CB    = wto_pkg::OUT_CNT_BITS;

	wto_pkg::sample_t mem_q [DEPTH];
	logic [PB-1:0]    wr_ptr_q;
	logic [PB-1:0]    rd_ptr_q;
	logic [CB-1:0]    count_q;
	logic             pop;

	assign result.valid  = (count_q != '0);
	assign result.sample = mem_q[rd_ptr_q];
	assign pop           = result.valid && result.ready;
	assign count         = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PB'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PB'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CB'(1);
				2'b01:   count_q <= count_q - CB'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// sample storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_sample;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CB'(DEPTH)) || pop)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |=> (count_q == '0) || (count_q == CB'(1)))
		else $error("result queue count jumped from empty");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_LEN = 1024;
	localparam int IDX_W     = 10;
	localparam int FRAC_W    = 22;
	localparam int PHASE_W   = IDX_W + FRAC_W;
	localparam int SAMPLE_W  = wto_pkg::SAMPLE_BITS;

	// kind code that the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// phase increment for 1024 entries at 48 kHz, Q0.32
	localparam logic [wto_pkg::SOR_BITS-1:0] SOR_48K = 32'd91625968;

	// expected samples of the oscillator, kept from accepted items
	class oscillator_checker;
		wto_pkg::sample_t                 wave [TABLE_LEN];
		bit                               loaded [TABLE_LEN];
		logic [PHASE_W-1:0]               phase;
		logic [wto_pkg::SOR_BITS-1:0]     size_over_rate;
		bit                               interpolate;
		logic [wto_pkg::START_BITS-1:0]   start_phase;
		wto_pkg::sample_t                 expected [$];
		int                               errors;

		function new();
			phase = '0;
			size_over_rate = '0;
			interpolate = 1'b1;
			start_phase = '0;
			errors = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void set_reg(wto_pkg::cfg_reg_t r, logic [wto_pkg::CFG_DATA_BITS-1:0] d);
			case (r)
				wto_pkg::CFG_SIZE_OVER_RATE: size_over_rate = d[wto_pkg::SOR_BITS-1:0];
				wto_pkg::CFG_INTERPOLATE:    interpolate = d[0];
				wto_pkg::CFG_START_PHASE:    start_phase = d[wto_pkg::START_BITS-1:0];
				default: ;
			endcase
		endfunction

		// sample at the current phase, truncated or interpolated to the next entry
		function wto_pkg::sample_t sample_at_phase();
			logic [IDX_W-1:0]                     idx;
			logic [IDX_W-1:0]                     nxt;
			logic [FRAC_W-1:0]                    frac;
			logic signed [SAMPLE_W:0]             t0;
			logic signed [SAMPLE_W:0]             t1;
			logic signed [SAMPLE_W:0]             diff;
			logic signed [SAMPLE_W:0]             val;
			logic signed [SAMPLE_W+FRAC_W+1:0]    prod;
			logic signed [SAMPLE_W+FRAC_W+1:0]    adj;
			idx = phase[PHASE_W-1 -: IDX_W];
			nxt = idx + 1'b1;
			frac = phase[FRAC_W-1:0];
			t0 = (SAMPLE_W+1)'(wave[idx]);
			t1 = (SAMPLE_W+1)'(wave[nxt]);
			val = t0;
			if (interpolate) begin
				diff = t1 - t0;
				prod = diff * $signed({1'b0, frac});
				adj = prod >>> FRAC_W;
				val = t0 + adj[SAMPLE_W:0];
			end
			return val[SAMPLE_W-1:0];
		endfunction

		// phase step is floor(freq * size_over_rate) at the phase resolution
		function void advance(logic signed [wto_pkg::FREQ_BITS-1:0] f);
			longint step;
			step = longint'(f) * longint'({32'd0, size_over_rate});
			step = step >>> (wto_pkg::PROD_FRAC_BITS - FRAC_W);
			phase = phase + step[PHASE_W-1:0];
		endfunction

		function void accept_item(logic [1:0] k, logic [wto_pkg::ADDR_BITS-1:0] a,
				logic [SAMPLE_W-1:0] e, logic [wto_pkg::FREQ_BITS-1:0] f);
			case (k)
				wto_pkg::KIND_LOAD: begin
					wave[a] = e;
					loaded[a] = 1'b1;
				end
				wto_pkg::KIND_RESTART: phase = {start_phase, 16'h0000};
				wto_pkg::KIND_TICK: begin
					expected.push_back(sample_at_phase());
					advance(f);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_sample(wto_pkg::sample_t s);
			wto_pkg::sample_t want;
			if (expected.size() == 0) begin
				report($sformatf("sample %0d with none expected", s));
			end else begin
				want = expected.pop_front();
				if (s !== want)
					report($sformatf("sample %0d, expected %0d", s, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   items_sent = 0;

	oscillator_checker osc = new();

	wto_item_if   item_ch();
	wto_result_if res_ch();
	wto_cfg_if    cfg_ch();

	wavetable_oscillator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// one item transfer, with an occasional gap in front of it
	task automatic send_item(logic [1:0] k, logic [wto_pkg::ADDR_BITS-1:0] a,
			logic [SAMPLE_W-1:0] e, logic [wto_pkg::FREQ_BITS-1:0] f);
		if (!calm && $urandom_range(3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.address <= a;
		item_ch.entry <= e;
		item_ch.freq <= f;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		osc.accept_item(k, a, e, f);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_entry();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [wto_pkg::FREQ_BITS-1:0] rand_freq();
		logic [wto_pkg::FREQ_BITS-1:0] f;
		case ($urandom_range(4))
			0: return $urandom;
			1: f = $urandom_range(20 << 16, 20000 << 16);
			2: f = $urandom_range(0, 2000);
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: f = $urandom_range(1 << 16, 440 << 16);
		endcase
		if ($urandom_range(1))
			f = -f;
		return f;
	endfunction

	// tick, loading first any entry it would read that was never written
	task automatic send_tick(logic [wto_pkg::FREQ_BITS-1:0] f);
		logic [IDX_W-1:0] idx;
		int i;
		for (i = 0; i < 2; i++) begin
			idx = osc.phase[PHASE_W-1 -: IDX_W] + i[IDX_W-1:0];
			if (!osc.loaded[idx])
				send_item(wto_pkg::KIND_LOAD, idx, rand_entry(), $urandom);
		end
		send_item(wto_pkg::KIND_TICK, 10'($urandom), 16'($urandom), f);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			send_tick(rand_freq());
		else if (r < 85)
			send_item(wto_pkg::KIND_LOAD, 10'($urandom), rand_entry(), $urandom);
		else if (r < 95)
			send_item(wto_pkg::KIND_RESTART, 10'($urandom), 16'($urandom), $urandom);
		else
			send_item(KIND_UNUSED, 10'($urandom), 16'($urandom), $urandom);
	endtask

	// all three registers in back-to-back transfers
	task automatic set_regs(logic [wto_pkg::SOR_BITS-1:0] sor, bit interp,
			logic [wto_pkg::START_BITS-1:0] start);
		wto_pkg::cfg_reg_t r;
		int i;
		cfg_ch.valid <= 1'b1;
		for (i = 0; i < 3; i++) begin
			r = wto_pkg::cfg_reg_t'(i);
			cfg_ch.index <= r;
			case (r)
				wto_pkg::CFG_SIZE_OVER_RATE: cfg_ch.data <= sor;
				wto_pkg::CFG_INTERPOLATE:    cfg_ch.data <= {31'd0, interp};
				default:                     cfg_ch.data <= {16'd0, start};
			endcase
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			case (r)
				wto_pkg::CFG_SIZE_OVER_RATE: osc.set_reg(r, sor);
				wto_pkg::CFG_INTERPOLATE:    osc.set_reg(r, {31'd0, interp});
				default:                     osc.set_reg(r, {16'd0, start});
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// no samples outstanding and the pipeline drained
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (osc.expected.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// result side: random ready bursts, one long hold-off, checking
	initial begin : result_side
		int stretch;
		int seen;
		bit held;
		res_ch.ready = 1'b0;
		stretch = 0;
		seen = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				osc.check_sample(res_ch.sample);
				seen++;
			end
			if (!held && seen == 100) begin
				// long hold-off so the result queue fills and input stalls
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				stretch = 0;
			end
			if (stretch == 0) begin
				res_ch.ready <= calm || ($urandom_range(2) != 0);
				stretch = $urandom_range(1, 16);
			end
			stretch--;
		end
	end

	initial begin : stimulus
		int p;
		int target;
		logic [wto_pkg::SOR_BITS-1:0] sor;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = wto_pkg::KIND_LOAD;
		item_ch.address = '0;
		item_ch.entry = '0;
		item_ch.freq = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = wto_pkg::CFG_SIZE_OVER_RATE;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table corners, wrap from the last entry to entry 0, extreme steps
		set_regs(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_item(wto_pkg::KIND_LOAD, 10'd0, 16'h7FFF, $urandom);
		send_item(wto_pkg::KIND_LOAD, 10'd1023, 16'h8000, $urandom);
		send_item(wto_pkg::KIND_LOAD, 10'd1, 16'h8000, $urandom);
		send_item(wto_pkg::KIND_LOAD, 10'd2, 16'h7FFF, $urandom);
		send_item(KIND_UNUSED, 10'($urandom), 16'($urandom), $urandom);
		send_item(wto_pkg::KIND_RESTART, 10'($urandom), 16'($urandom), $urandom);
		send_tick(32'd0);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		send_tick(32'hFFFF_FFFF);

		// smallest negative step lands on the largest fraction
		wait_idle();
		set_regs(32'd1, 1'b1, 16'h0000);
		send_item(wto_pkg::KIND_RESTART, 10'($urandom), 16'($urandom), $urandom);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd0);
		send_tick(32'd1);

		// truncating lookup, zero step, mid-table restart
		wait_idle();
		set_regs(32'd0, 1'b0, 16'h8000);
		send_item(wto_pkg::KIND_RESTART, 10'($urandom), 16'($urandom), $urandom);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);

		// random phases, the last one without idling
		for (p = 0; p < 6; p++) begin
			wait_idle();
			calm = (p == 5);
			case (p % 4)
				0: sor = $urandom;
				1: sor = SOR_48K;
				2: sor = $urandom_range(1, 1 << 20);
				default: sor = 32'hFFFF_FFFF - $urandom_range(0, 255);
			endcase
			set_regs(sor, 1'($urandom_range(1)), 16'($urandom));
			target = items_sent + 105;
			while (items_sent < target)
				random_item();
		end

		wait_idle();
		if (osc.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/wto_pkg.sv
sv/wto_if.sv
sv/wto_table.sv
sv/wto_phase.sv
sv/wto_interp.sv
sv/wto_outq.sv
sv/wavetable_oscillator.sv
verif/testbench.sv
